// File: hw/rtl/pll_pkg.sv
package pll_pkg;

    localparam int PLL_CAPACITY = 16;
    localparam int VAL_W        = 32;
    localparam int FUNC_W       = 2;
    localparam int POS_W        = 5;
    localparam int STAT_W       = 2;
    localparam int CNT_OUT_W    = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_READ   = 2'd1,
        FN_REMOVE = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_WALK,
        S_RD,
        S_RD2,
        S_RM,
        S_RM2,
        S_IN1,
        S_IN2,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load_in;
        logic check;
        logic walk;
        logic walk_end;
        logic rd_issue;
        logic rd_capture;
        logic rm_issue;
        logic rm_commit;
        logic ins_alloc;
        logic ins_link;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  reject;
        logic  steps_zero;
        logic  out_busy;
    } t_sts;

endpackage

// File: hw/rtl/pll_ram.sv
module pll_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/pll_ctrl.sv
module pll_ctrl
    import pll_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.reject || i_sts.func == FN_NONE) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_sts.steps_zero) begin
                    unique case (i_sts.func)
                        FN_READ:   n_state = S_RD;
                        FN_REMOVE: n_state = S_RM;
                        FN_INSERT: n_state = S_IN1;
                        default:   n_state = S_FIN;
                    endcase
                end
            end
            S_RD:  n_state = S_RD2;
            S_RD2: n_state = S_FIN;
            S_RM:  n_state = S_RM2;
            S_RM2: n_state = S_FIN;
            S_IN1: n_state = S_IN2;
            S_IN2: n_state = S_FIN;
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_CHECK: o_cmd.check = 1'b1;
            S_WALK: begin
                o_cmd.walk     = !i_sts.steps_zero;
                o_cmd.walk_end = i_sts.steps_zero;
            end
            S_RD:  o_cmd.rd_issue   = 1'b1;
            S_RD2: o_cmd.rd_capture = 1'b1;
            S_RM:  o_cmd.rm_issue   = 1'b1;
            S_RM2: o_cmd.rm_commit  = 1'b1;
            S_IN1: o_cmd.ins_alloc  = 1'b1;
            S_IN2: o_cmd.ins_link   = 1'b1;
            S_FIN: o_cmd.out_load   = !i_sts.out_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: hw/rtl/pll_dp.sv
module pll_dp
    import pll_pkg::*;
#(
    parameter int CAPACITY = PLL_CAPACITY
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_cmd                        i_cmd,
    output t_sts                        o_sts,
    input  logic [FUNC_W-1:0]           i_func,
    input  logic [POS_W-1:0]            i_position,
    input  logic signed [VAL_W-1:0]     i_value,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic signed [VAL_W-1:0]     o_read_value,
    output logic [STAT_W-1:0]           o_status,
    output logic [CNT_OUT_W-1:0]        o_element_count,
    output logic                        o_is_empty
);

    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int CW = LW;
    localparam int SW = CW + 1;
    localparam int MW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam logic [LW-1:0] NIL = LW'(CAPACITY);

    // Transaction registers
    t_func              r_func;
    logic [POS_W-1:0]   r_pos;
    logic [VAL_W-1:0]   r_val;
    logic [POS_W-1:0]   r_steps;
    logic [LW-1:0]      r_cur;
    logic [LW-1:0]      r_prev;
    logic [AW-1:0]      r_node;
    logic [VAL_W-1:0]   r_rd;
    t_status            r_status;
    logic               r_pend;

    // List state
    logic [LW-1:0]      r_first;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_free_cnt;
    logic [CW-1:0]      r_free_min;

    // Result register
    logic               r_ovalid;
    logic [VAL_W-1:0]   r_out_rd;
    t_status            r_out_status;
    logic [CW-1:0]      r_out_count;

    logic [LW-1:0]      link_rdata;
    logic [VAL_W-1:0]   value_rdata;
    logic [AW-1:0]      free_rdata;

    logic [LW-1:0]      eff_cur;
    logic [CW-1:0]      top_cnt;
    logic [AW-1:0]      alloc_node;
    logic               top_fresh;
    logic [MW-1:0]      pos_ext;
    logic [MW-1:0]      cnt_ext;
    t_status            chk_status;

    logic               link_we;
    logic [AW-1:0]      link_waddr;
    logic [LW-1:0]      link_wdata;
    logic               link_re;
    logic [AW-1:0]      link_raddr;

    // While a link read is in flight, the walk pointer lives in the RAM output.
    assign eff_cur = r_pend ? link_rdata : r_cur;

    // Free-stack entries below the lowest fill level reached still hold their index.
    assign top_cnt    = r_free_cnt - 1'b1;
    assign top_fresh  = top_cnt < r_free_min;
    assign alloc_node = top_fresh ? top_cnt[AW-1:0] : free_rdata;

    assign pos_ext = MW'(r_pos);
    assign cnt_ext = MW'(r_count);

    always_comb begin
        chk_status = ST_OK;
        case (r_func) inside
            FN_INSERT: begin
                if (r_pos == '0 || pos_ext > cnt_ext + MW'(1)) begin
                    chk_status = ST_BAD_POS;
                end else if (r_free_cnt == '0) begin
                    chk_status = ST_FULL;
                end
            end
            FN_READ, FN_REMOVE: begin
                if (r_pos == '0 || pos_ext > cnt_ext) begin
                    chk_status = ST_BAD_POS;
                end
            end
            default: chk_status = ST_OK;
        endcase
    end

    assign o_sts.func       = r_func;
    assign o_sts.reject     = chk_status != ST_OK;
    assign o_sts.steps_zero = r_steps == '0;
    assign o_sts.out_busy   = r_ovalid && !i_out_ready;

    assign link_re    = (i_cmd.walk && eff_cur != NIL) || i_cmd.rm_issue;
    assign link_raddr = i_cmd.rm_issue ? r_cur[AW-1:0] : eff_cur[AW-1:0];

    always_comb begin
        link_we    = 1'b0;
        link_waddr = r_prev[AW-1:0];
        link_wdata = link_rdata;
        if (i_cmd.ins_alloc) begin
            link_we    = 1'b1;
            link_waddr = alloc_node;
            link_wdata = r_cur;
        end else if (i_cmd.ins_link) begin
            link_we    = r_prev != NIL;
            link_wdata = LW'(r_node);
        end else if (i_cmd.rm_commit) begin
            link_we    = r_prev != NIL;
        end
    end

    pll_ram #(
        .WIDTH (LW),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    pll_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_alloc),
        .i_waddr (alloc_node),
        .i_wdata (r_val),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (r_cur[AW-1:0]),
        .o_rdata (value_rdata)
    );

    pll_ram #(
        .WIDTH (AW),
        .DEPTH (CAPACITY)
    ) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.rm_commit),
        .i_waddr (r_free_cnt[AW-1:0]),
        .i_wdata (r_cur[AW-1:0]),
        .i_re    (i_cmd.check),
        .i_raddr (top_cnt[AW-1:0]),
        .o_rdata (free_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend     <= 1'b0;
            r_first    <= NIL;
            r_count    <= '0;
            r_free_cnt <= CW'(CAPACITY);
            r_free_min <= CW'(CAPACITY);
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cmd.check) begin
                r_pend <= 1'b0;
            end
            if (i_cmd.walk) begin
                if (eff_cur == NIL) begin
                    r_pend <= 1'b0;
                end else begin
                    r_pend <= 1'b1;
                end
            end
            if (i_cmd.walk_end) begin
                r_pend <= 1'b0;
            end
            if (i_cmd.ins_alloc) begin
                r_free_cnt <= top_cnt;
                r_count    <= r_count + 1'b1;
                if (top_fresh) begin
                    r_free_min <= top_cnt;
                end
            end
            if (i_cmd.ins_link && r_prev == NIL) begin
                r_first <= LW'(r_node);
            end
            if (i_cmd.rm_commit) begin
                r_free_cnt <= r_free_cnt + 1'b1;
                r_count    <= r_count - 1'b1;
                if (r_prev == NIL) begin
                    r_first <= link_rdata;
                end
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func <= t_func'(i_func);
            r_pos  <= i_position;
            r_val  <= i_value;
        end
        if (i_cmd.check) begin
            r_steps  <= r_pos;
            r_cur    <= NIL;
            r_status <= chk_status;
            r_rd     <= '0;
        end
        if (i_cmd.walk) begin
            r_prev  <= eff_cur;
            r_steps <= r_steps - 1'b1;
            if (eff_cur == NIL) begin
                r_cur <= r_first;
            end
        end
        if (i_cmd.walk_end) begin
            r_cur <= eff_cur;
        end
        if (i_cmd.rd_capture) begin
            r_rd <= value_rdata;
        end
        if (i_cmd.ins_alloc) begin
            r_node <= alloc_node;
        end
        if (i_cmd.out_load) begin
            r_out_rd     <= r_rd;
            r_out_status <= r_status;
            r_out_count  <= r_count;
        end
    end

    assign o_out_valid     = r_ovalid;
    assign o_read_value    = r_out_rd;
    assign o_status        = r_out_status;
    assign o_element_count = CNT_OUT_W'(r_out_count);
    assign o_is_empty      = r_out_count == '0;

    a_node_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SW'(r_count) + SW'(r_free_cnt) == SW'(CAPACITY))
        else $error("element count and free count do not add up to capacity");

    a_free_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_min <= r_free_cnt)
        else $error("free stack low mark above fill level");

    a_alloc_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_alloc |-> r_free_cnt != '0)
        else $error("node allocated from an empty free stack");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.walk, i_cmd.rd_issue, i_cmd.rm_issue, i_cmd.rm_commit,
                  i_cmd.ins_alloc, i_cmd.ins_link}))
        else $error("conflicting memory commands");

    a_result_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_ovalid)
        else $error("result register not loaded");

endmodule

// File: hw/rtl/positional_linked_list_top.sv
// Sequencing: a rejected or unused-code transaction goes from the check state to the
// result load; read, insert and remove first walk the list to the position, and the
// walk follows one link per cycle through the registered link memory.
// Throughput: one transaction in flight; the next is taken once its result is loaded.
// Reset: i_rst_n is synchronous, active low; it empties the list and refills the
// free stack at once, with no memory clearing pass.
module positional_linked_list_top
    import pll_pkg::*;
#(
    parameter int CAPACITY = PLL_CAPACITY
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [FUNC_W-1:0]       i_func,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic [STAT_W-1:0]       o_status,
    output logic [CNT_OUT_W-1:0]    o_element_count,
    output logic                    o_is_empty
);

    t_cmd cmd;
    t_sts sts;

    pll_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pll_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_func          (i_func),
        .i_position      (i_position),
        .i_value         (i_value),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_read_value    (o_read_value),
        .o_status        (o_status),
        .o_element_count (o_element_count),
        .o_is_empty      (o_is_empty)
    );

endmodule
